// File: src/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/bgnc_pkg.sv
`timescale 1ns / 1ps
package bgnc_pkg;

  localparam int CFG_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_MAX     = (1 << CFG_W) - 1;
  localparam int SIZE_RST    = 10;
  localparam int POS_W       = 5;
  localparam int COUNT_W     = 4;
  localparam int WIN_SIDE    = 3;
  localparam int WIN_N       = WIN_SIDE * WIN_SIDE;
  localparam int WIN_IDX_W   = $clog2(WIN_N);
  localparam int PEND_N      = 4;
  localparam int PICK_W      = $clog2(PEND_N);
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

  // Cells an item can report, in the order they leave the block. The window
  // is indexed row_back * 3 + col_back, counted back from the newest cell.
  localparam logic [PICK_W-1:0] PICK_UL   = PICK_W'(0);  // row above, column left
  localparam logic [PICK_W-1:0] PICK_UP   = PICK_W'(1);  // row above, same column
  localparam logic [PICK_W-1:0] PICK_LEFT = PICK_W'(2);  // same row, column left
  localparam logic [PICK_W-1:0] PICK_HERE = PICK_W'(3);  // the newest cell itself

  // Window positions that are neighbours of the reported cell, per pick.
  localparam logic [WIN_N-1:0] NB_MASK [PEND_N] = '{
    9'h1EF, 9'h0D3, 9'h03D, 9'h01A
  };
  // Window position of the reported cell itself, per pick.
  localparam logic [WIN_IDX_W-1:0] OWN_IDX [PEND_N] = '{
    4'd4, 4'd3, 4'd1, 4'd0
  };

  typedef struct packed {
    logic [PEND_N-1:0] pend;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [WIN_N-1:0]  win;
  } item_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] max_v);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > max_v) begin
      res = max_v;
    end
    return res;
  endfunction

endpackage

// File: src/bgnc_cell.sv
`timescale 1ns / 1ps
module bgnc_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic shift_en,
  input  logic d,
  output logic q
);

  logic val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else if (shift_en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

// File: src/bgnc_chain.sv
`timescale 1ns / 1ps
module bgnc_chain #(
  parameter int DEPTH = 67
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic                       din,
  input  logic [bgnc_pkg::CFG_W-1:0] cols,
  output logic [bgnc_pkg::WIN_N-1:0] taps
);

  import bgnc_pkg::*;

  // link[k+1] is the cell k places back from the newest item.
  logic [DEPTH:0] link;

  assign link[0] = din;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    bgnc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (link[k]),
      .q        (link[k+1])
    );
  end

  // The two older rows sit one and two grid widths back along the chain.
  always_comb begin
    taps = '0;
    for (int c = 0; c < WIN_SIDE; c++) begin
      taps[c] = link[c+1];
    end
    for (int k = 0; k < DEPTH; k++) begin
      for (int r = 1; r < WIN_SIDE; r++) begin
        for (int c = 0; c < WIN_SIDE; c++) begin
          if (k == r * int'(cols) + c) begin
            taps[r*WIN_SIDE+c] = link[k+1];
          end
        end
      end
    end
  end

endmodule

// File: src/bgnc_emit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bgnc_emit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ld_v,
  input  bgnc_pkg::item_t                  ld_item,
  output logic                             ld_rdy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bgnc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  output logic [bgnc_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import bgnc_pkg::*;

  logic               s2_v_r, s2_v_nxt;
  item_t              s2_item_r, s2_item_nxt;
  logic               out_v_r, out_v_nxt;
  logic [COUNT_W-1:0] out_cnt_r, cnt;
  logic               out_own_r;
  logic [POS_W-1:0]   out_row_r, out_col_r;
  logic               out_last_r, out_fd_r;

  logic [PICK_W-1:0]  pick_idx;
  logic [PEND_N-1:0]  pick_oh, rest;
  logic [WIN_N-1:0]   nb;
  logic               is_last, out_free, emit_go, back_row, back_col, own;
  logic [POS_W-1:0]   row_a, col_b;

  always_comb begin
    priority if (s2_item_r.pend[PICK_UL]) begin
      pick_idx = PICK_UL;
    end else if (s2_item_r.pend[PICK_UP]) begin
      pick_idx = PICK_UP;
    end else if (s2_item_r.pend[PICK_LEFT]) begin
      pick_idx = PICK_LEFT;
    end else begin
      pick_idx = PICK_HERE;
    end
  end

  assign pick_oh  = PEND_N'(1) << pick_idx;
  assign rest     = s2_item_r.pend & ~pick_oh;
  assign is_last  = (rest == '0);
  assign out_free = !out_v_r || out_tready;
  assign emit_go  = s2_v_r && out_free;
  assign ld_rdy   = !s2_v_r || (emit_go && is_last);

  assign back_row = (pick_idx == PICK_UL) || (pick_idx == PICK_UP);
  assign back_col = (pick_idx == PICK_UL) || (pick_idx == PICK_LEFT);
  assign row_a    = s2_item_r.row - POS_W'(back_row);
  assign col_b    = s2_item_r.col - POS_W'(back_col);
  assign nb       = NB_MASK[pick_idx];
  assign own      = s2_item_r.win[OWN_IDX[pick_idx]];

  always_comb begin
    cnt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      cnt = cnt + COUNT_W'(s2_item_r.win[i] & nb[i]);
    end
  end

  always_comb begin
    s2_v_nxt    = ld_rdy ? ld_v : s2_v_r;
    s2_item_nxt = s2_item_r;
    if (ld_rdy && ld_v) begin
      s2_item_nxt = ld_item;
    end else if (emit_go) begin
      s2_item_nxt.pend = rest;
    end
    out_v_nxt = out_free ? emit_go : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r <= s2_item_nxt;
    if (emit_go) begin
      out_cnt_r  <= cnt;
      out_own_r  <= own;
      out_row_r  <= row_a;
      out_col_r  <= col_b;
      out_last_r <= is_last;
      out_fd_r   <= (pick_idx == PICK_HERE);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({out_col_r, out_row_r, out_own_r, out_cnt_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = OUT_TUSER_W'(out_fd_r);

  `ASSERT_SYNC(a_s2_pend_nonzero, clk, rst_n, s2_v_r |-> (s2_item_r.pend != '0), "held item has no cell left to report")
  `ASSERT_SYNC(a_s2_stays_until_last, clk, rst_n, (emit_go && !is_last) |=> s2_v_r, "item dropped before its last result")
  `ASSERT_SYNC(a_frame_done_is_last, clk, rst_n, (out_v_r && out_fd_r) |-> out_last_r, "frame end result not last of its item")

endmodule

// File: src/binary_grid_neighbor_count_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// 3x3 neighbour counter for a binary grid streamed in raster order.
// in_*  : one cell bit per item (in_tdata[0]), row-major, grid_rows x grid_cols.
// out_* : one result per cell with its neighbour count (0..8), its own bit and
//         its row and column. tlast marks the last result caused by one input
//         item, tuser[0] marks the result for the grid's last cell.
// cfg_* : index 0 writes grid_cols, index 1 writes grid_rows (0 acts as 1, values
//         above the maximum act as the maximum). Either write restarts the frame
//         at row 0, column 0. Write only while the block is idle.
// A cell is reported once the input below and to its right has arrived, so the
// first row of a taller grid gives nothing and the last row's inputs flush that row.
// An item passes stage one and the held-item stage before its results are
// registered. Throughput: one input item per cycle while out_tready is high and
// no item reports more than one cell; the single result register hands out one
// cell per cycle, so an input that reports more holds in_tready low longer.
// Reset clears the cell chain and sets a 10 x 10 grid; there is no clearing pass.
// When out_tready is low the result register holds, one further item waits in
// each of the two internal stages, and then in_tready falls.
module binary_grid_neighbor_count_unit #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bgnc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] cell_bit
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] neighbor_count, [4] own_bit, [9:5] out_row, [14:10] out_col
  output logic [bgnc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  output logic [bgnc_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] frame_done
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bgnc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgnc_pkg::CFG_W-1:0]       cfg_data
);

  import bgnc_pkg::*;

  localparam int ROWS_CAP = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
  localparam int RW       = $clog2(ROWS_CAP);
  localparam int CW       = $clog2(MAX_COLS);
  localparam int DEPTH    = 2 * MAX_COLS + 3;
  localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(ROWS_CAP);
  localparam logic [CFG_W-1:0] COLS_RST = CFG_W'((MAX_COLS < SIZE_RST) ? MAX_COLS : SIZE_RST);
  localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'((ROWS_CAP < SIZE_RST) ? ROWS_CAP : SIZE_RST);

  logic [CFG_W-1:0]  cols_r, cols_nxt, rows_r, rows_nxt;
  logic [RW-1:0]     in_row_r, in_row_nxt, s1_row_r;
  logic [CW-1:0]     in_col_r, in_col_nxt, s1_col_r;
  logic              s1_v_r, s1_v_nxt;
  logic [PEND_N-1:0] s1_pend_r, pend;

  logic              in_accept, cfg_we, cfg_restart, col_last, row_last;
  logic              s1_move, ld_v, ld_rdy;
  logic [WIN_N-1:0]  taps, win;
  logic [WIN_SIDE-1:0] row_ok, col_ok;
  item_t             ld_item;

  assign cfg_ready   = 1'b1;
  assign cfg_we      = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_we && ((cfg_index == REG_GRID_COLS) || (cfg_index == REG_GRID_ROWS));
  assign in_accept   = in_tvalid && in_tready;

  assign col_last = (CFG_W'(in_col_r) == cols_r - CFG_W'(1));
  assign row_last = (CFG_W'(in_row_r) == rows_r - CFG_W'(1));

  // Cells this input completes: row above and/or own row, column left and/or own.
  assign pend[PICK_UL]   = (in_row_r != '0) && (in_col_r != '0);
  assign pend[PICK_UP]   = (in_row_r != '0) && col_last;
  assign pend[PICK_LEFT] = row_last && (in_col_r != '0);
  assign pend[PICK_HERE] = row_last && col_last;

  // The chain only moves while no earlier item still needs its window.
  assign ld_v      = s1_v_r && (s1_pend_r != '0);
  assign s1_move   = s1_v_r && ((s1_pend_r == '0) || ld_rdy);
  assign in_tready = !s1_v_r || s1_move;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_we) begin
      priority if (cfg_index == REG_GRID_COLS) begin
        cols_nxt = clamp_size(cfg_data, COLS_MAX);
      end else if (cfg_index == REG_GRID_ROWS) begin
        rows_nxt = clamp_size(cfg_data, ROWS_MAX);
      end else begin
        cols_nxt = cols_r;
      end
    end

    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (cfg_restart) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end else if (in_accept) begin
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = row_last ? '0 : in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end

    s1_v_nxt = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= COLS_RST;
      rows_r   <= ROWS_RST;
      in_row_r <= '0;
      in_col_r <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      cols_r   <= cols_nxt;
      rows_r   <= rows_nxt;
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      s1_v_r   <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_row_r  <= in_row_r;
      s1_col_r  <= in_col_r;
      s1_pend_r <= pend;
    end
  end

  bgnc_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_accept),
    .din      (in_tdata[0]),
    .cols     (cols_r),
    .taps     (taps)
  );

  // Window cells above row 0 or left of column 0 lie outside the grid.
  assign row_ok = {s1_row_r > RW'(1), s1_row_r != '0, 1'b1};
  assign col_ok = {s1_col_r > CW'(1), s1_col_r != '0, 1'b1};

  always_comb begin
    for (int r = 0; r < WIN_SIDE; r++) begin
      for (int c = 0; c < WIN_SIDE; c++) begin
        win[r*WIN_SIDE+c] = taps[r*WIN_SIDE+c] & row_ok[r] & col_ok[c];
      end
    end
  end

  assign ld_item.pend = s1_pend_r;
  assign ld_item.row  = POS_W'(s1_row_r);
  assign ld_item.col  = POS_W'(s1_col_r);
  assign ld_item.win  = win;

  bgnc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_v       (ld_v),
    .ld_item    (ld_item),
    .ld_rdy     (ld_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `ASSERT_ALWAYS(a_reset_empties_s1, clk, !rst_n |=> !s1_v_r, "stage one holds an item after reset")
  `ASSERT_SYNC(a_accept_fills_s1, clk, rst_n, in_accept |=> s1_v_r, "accepted item lost before stage one")
  `ASSERT_SYNC(a_pos_in_grid, clk, rst_n, (CFG_W'(in_row_r) < rows_r) && (CFG_W'(in_col_r) < cols_r), "input position outside the grid")

endmodule

// File: tb/sv/binary_grid_neighbor_count_unit_tb.sv
`timescale 1ns / 1ps
module binary_grid_neighbor_count_unit_tb;
  import bgnc_pkg::*;

  localparam int GRID_MAX      = 32;
  localparam int CHAIN_LEN     = 2 * GRID_MAX + 3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 436;

  typedef struct {
    logic [COUNT_W-1:0] nb_count;
    logic               own_bit;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               last_of_run;
    logic               frame_done;
  } cell_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Shadow of the block: register values as written, the recent cells with the
  // newest in bit 0, and the position of the next input item.
  logic [CFG_W-1:0]       grid_cols_reg = CFG_W'(SIZE_RST);
  logic [CFG_W-1:0]       grid_rows_reg = CFG_W'(SIZE_RST);
  logic [CHAIN_LEN-1:0]   recent_cells = '0;
  int                     next_row = 0;
  int                     next_col = 0;

  cell_report_t           neighbour_reports[$];
  int                     mismatches = 0;
  bit                     quiet = 1'b0;

  binary_grid_neighbor_count_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int fit_size(input logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > GRID_MAX) return GRID_MAX;
    return int'(raw);
  endfunction

  function automatic logic chain_at(input int off);
    if (off < 0 || off >= CHAIN_LEN) return 1'b0;
    return recent_cells[off];
  endfunction

  // Shifts one accepted cell into the shadow chain and queues every cell whose
  // neighbourhood it completes, in raster order.
  task automatic count_cell_neighbours(input logic bit_v);
    int                 cols, rows, r, c, a, b, yr, xc, nr, nc, i, j, k;
    int                 ra[2];
    int                 cb[2];
    logic [COUNT_W-1:0] n;
    cell_report_t       found[4];
    cols = fit_size(grid_cols_reg);
    rows = fit_size(grid_rows_reg);
    if (next_row >= rows || next_col >= cols) begin
      next_row = 0;
      next_col = 0;
    end
    r = next_row;
    c = next_col;
    recent_cells = {recent_cells[CHAIN_LEN-2:0], bit_v};
    nr = 0;
    nc = 0;
    k = 0;
    if (r >= 1) begin
      ra[nr] = r - 1;
      nr++;
    end
    if (r == rows - 1) begin
      ra[nr] = r;
      nr++;
    end
    if (c >= 1) begin
      cb[nc] = c - 1;
      nc++;
    end
    if (c == cols - 1) begin
      cb[nc] = c;
      nc++;
    end
    for (i = 0; i < nr; i++) begin
      for (j = 0; j < nc; j++) begin
        a = ra[i];
        b = cb[j];
        n = '0;
        for (yr = a - 1; yr <= a + 1; yr++) begin
          for (xc = b - 1; xc <= b + 1; xc++) begin
            if (!(yr == a && xc == b) && yr >= 0 && yr < rows && xc >= 0 && xc < cols) begin
              n += COUNT_W'(chain_at((r - yr) * cols + (c - xc)));
            end
          end
        end
        found[k].nb_count    = n;
        found[k].own_bit     = chain_at((r - a) * cols + (c - b));
        found[k].row         = POS_W'(a);
        found[k].col         = POS_W'(b);
        found[k].last_of_run = 1'b0;
        found[k].frame_done  = (a == rows - 1 && b == cols - 1);
        k++;
      end
    end
    for (i = 0; i < k; i++) begin
      found[i].last_of_run = (i == k - 1);
      neighbour_reports.push_back(found[i]);
    end
    next_col++;
    if (next_col >= cols) begin
      next_col = 0;
      next_row++;
      if (next_row >= rows) next_row = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want_v);
    $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want_v);
    mismatches++;
  endtask

  // Result side: random back-pressure except during the quiet stretch.
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    cell_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (neighbour_reports.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = neighbour_reports.pop_front();
        if (out_tdata[3:0] != want.nb_count)
          report_mismatch("neighbor_count", out_tdata[3:0], want.nb_count);
        if (out_tdata[4] != want.own_bit)
          report_mismatch("own_bit", out_tdata[4], want.own_bit);
        if (out_tdata[9:5] != want.row)
          report_mismatch("out_row", out_tdata[9:5], want.row);
        if (out_tdata[14:10] != want.col)
          report_mismatch("out_col", out_tdata[14:10], want.col);
        if (out_tlast != want.last_of_run)
          report_mismatch("last_of_run", out_tlast, want.last_of_run);
        if (out_tuser[0] != want.frame_done)
          report_mismatch("frame_done", out_tuser[0], want.frame_done);
      end
    end
  end

  // The valid is only lowered inside a gap, so a back-to-back item never sees
  // two assignments to it in one time step.
  task automatic send_cell_bit(input logic bit_v);
    while (!quiet && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, bit_v};
    do @(posedge clk); while (!in_tready);
    count_cell_neighbours(bit_v);
  endtask

  task automatic wait_for_reports(input bit settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (neighbour_reports.size() != 0);
    // An item that reports nothing may still be in flight.
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    while (!quiet && $urandom_range(99) < 10) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_GRID_COLS) grid_cols_reg = val;
    else grid_rows_reg = val;
    next_row = 0;
    next_col = 0;
  endtask

  // order: 0 columns then rows, 1 rows then columns, 2 columns only, 3 rows only.
  task automatic set_grid(input logic [CFG_W-1:0] cols_v, input logic [CFG_W-1:0] rows_v,
                          input int order);
    if (order == 1 || order == 3) write_reg(REG_GRID_ROWS, rows_v);
    if (order != 3) write_reg(REG_GRID_COLS, cols_v);
    if (order == 0) write_reg(REG_GRID_ROWS, rows_v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(7))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'($urandom_range(GRID_MAX + 1, CFG_MAX));
      3: return CFG_W'(GRID_MAX);
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  // The reset grid is 10 x 10; the first row reports nothing, and the partial
  // frame is cut short by the next register write.
  task automatic test_reset_grid();
    logic [11:0] pattern;
    int          i;
    pattern = 12'b1011_0010_1101;
    for (i = 0; i < 12; i++) send_cell_bit(pattern[i]);
    wait_for_reports(1'b1);
  endtask

  // Zero sizes act as one: every item is a whole frame of its own.
  task automatic test_unit_grid();
    set_grid('0, '0, 0);
    send_cell_bit(1'b1);
    send_cell_bit(1'b0);
    send_cell_bit(1'b1);
    wait_for_reports(1'b1);
  endtask

  // A full 3 x 3 board gives the centre all eight neighbours.
  task automatic test_full_window();
    int i;
    set_grid(CFG_W'(3), CFG_W'(3), 1);
    for (i = 0; i < 9; i++) send_cell_bit(1'b1);
    wait_for_reports(1'b1);
  endtask

  // Phase four is the long stretch with neither side idling.
  task automatic test_random_frames();
    int sent, phase, frame_len, n_items, density, hold_at, i;
    logic [CFG_W-1:0] cols_v, rows_v;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_for_reports(1'b1);
      case (phase)
        0: begin
          cols_v = CFG_W'(CFG_MAX);
          rows_v = CFG_W'(2);
        end
        1: begin
          cols_v = CFG_W'(1);
          rows_v = CFG_W'(GRID_MAX);
        end
        2: begin
          cols_v = CFG_W'(GRID_MAX);
          rows_v = CFG_W'(1);
        end
        4: begin
          cols_v = CFG_W'(GRID_MAX);
          rows_v = CFG_W'(3);
        end
        default: begin
          cols_v = pick_size();
          rows_v = pick_size();
        end
      endcase
      set_grid(cols_v, rows_v, (phase < 3) ? 0 : $urandom_range(3));
      frame_len = fit_size(grid_cols_reg) * fit_size(grid_rows_reg);
      n_items = frame_len * $urandom_range(1, 2);
      if (n_items > 96) n_items = 96;
      if (n_items > RANDOM_ITEMS - sent) n_items = RANDOM_ITEMS - sent;
      if ((phase == 3 || phase > 4) && $urandom_range(4) == 0)
        n_items = $urandom_range(1, n_items);
      case ($urandom_range(3))
        0: density = 5;
        1: density = 50;
        2: density = 92;
        default: density = $urandom_range(100);
      endcase
      quiet = (phase == 4);
      hold_at = (phase == 0 || (phase != 4 && $urandom_range(1) == 1)) ?
                $urandom_range(n_items - 1) : -1;
      for (i = 0; i < n_items; i++) begin
        if (i == hold_at) wait_for_reports(1'b0);
        send_cell_bit($urandom_range(99) < density);
      end
      sent += n_items;
      phase++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_grid();
    test_unit_grid();
    test_full_window();
    test_random_frames();
    wait_for_reports(1'b1);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
